### hw/rtl/slir_pkg.sv
package slir_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int COUNT_W  = 5;
	localparam int DATA_W   = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_REMOVE = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] STATUS_DONE      = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

	typedef struct packed {
		logic                     ins;
		logic                     rem;
		logic signed [DATA_W-1:0] value;
	} cell_op_t;

endpackage

### hw/rtl/sorted_list_insert_remove.sv
// Result path: the taken start beat is registered in pend_s1, and done is registered from pend_s1.
// Throughput: one operation per cycle; busy stays low, all 16 cells compare
// against the value in parallel and shift in the same cycle.
// Reset: arst_n clears the entry count (list empty) and the result strobe;
// cell contents are not reset. The receiver cannot stall: done lasts one cycle.
module sorted_list_insert_remove (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          mode,
	input  logic signed [slir_pkg::DATA_W-1:0]  value,
	output logic                                done,
	output logic [1:0]                          status,
	output logic [slir_pkg::COUNT_W-1:0]        entry_count,
	output logic signed [slir_pkg::DATA_W-1:0]  smallest,
	output logic signed [slir_pkg::DATA_W-1:0]  largest
);

	localparam int N = slir_pkg::CAPACITY;

	logic                          accept;
	logic                          full;
	logic                          found;
	slir_pkg::cell_op_t            op;
	logic [slir_pkg::CNT_W-1:0]    occ_q;
	logic                          pend_s1;
	logic [1:0]                    status_s1;
	logic [slir_pkg::IDX_W-1:0]    tail_idx;

	logic signed [slir_pkg::DATA_W-1:0] cell_val [N];
	logic                               cell_lt  [N];
	logic                               cell_hit [N];

	assign busy   = 1'b0;
	assign accept = start && !busy;
	assign full   = (occ_q == slir_pkg::CNT_W'(N));
	assign found  = cell_hit[N-1];

	assign op.ins   = accept && (mode == slir_pkg::MODE_INSERT) && !full;
	assign op.rem   = accept && (mode == slir_pkg::MODE_REMOVE);
	assign op.value = value;

	for (genvar i = 0; i < N; i++) begin : g_cell
		slir_cell u_cell (
			.clk       (clk),
			.op        (op),
			.live      (occ_q > slir_pkg::CNT_W'(i)),
			.left_val  ((i == 0) ? value : cell_val[(i == 0) ? 0 : i - 1]),
			.left_lt   ((i == 0) ? 1'b1 : cell_lt[(i == 0) ? 0 : i - 1]),
			.right_val (cell_val[(i == N - 1) ? i : i + 1]),
			.hit_in    ((i == 0) ? 1'b0 : cell_hit[(i == 0) ? 0 : i - 1]),
			.lt        (cell_lt[i]),
			.hit_out   (cell_hit[i]),
			.val       (cell_val[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= accept;
			if (accept) begin
				unique case (mode)
					slir_pkg::MODE_INSERT: if (!full) occ_q <= occ_q + 1'b1;
					slir_pkg::MODE_REMOVE: if (found) occ_q <= occ_q - 1'b1;
					slir_pkg::MODE_CLEAR:  occ_q <= '0;
					default:               occ_q <= occ_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode == slir_pkg::MODE_INSERT && full) begin
				status_s1 <= slir_pkg::STATUS_FULL;
			end else if (mode == slir_pkg::MODE_REMOVE && !found) begin
				status_s1 <= slir_pkg::STATUS_NOT_FOUND;
			end else begin
				status_s1 <= slir_pkg::STATUS_DONE;
			end
		end
	end

	assign tail_idx = slir_pkg::IDX_W'(occ_q - 1'b1);

	// sample the list state left by the previous beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= pend_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			status      <= status_s1;
			entry_count <= slir_pkg::COUNT_W'(occ_q);
			if (occ_q == '0) begin
				smallest <= '0;
				largest  <= '0;
			end else begin
				smallest <= cell_val[0];
				largest  <= cell_val[tail_idx];
			end
		end
	end

endmodule

### hw/rtl/slir_cell.sv
module slir_cell (
	input  logic                              clk,
	input  slir_pkg::cell_op_t                op,
	input  logic                              live,
	input  logic signed [slir_pkg::DATA_W-1:0] left_val,
	input  logic                              left_lt,
	input  logic signed [slir_pkg::DATA_W-1:0] right_val,
	input  logic                              hit_in,
	output logic                              lt,
	output logic                              hit_out,
	output logic signed [slir_pkg::DATA_W-1:0] val
);

	logic signed [slir_pkg::DATA_W-1:0] val_q;
	logic                              eq;

	assign lt      = live && (val_q < op.value);
	assign eq      = live && (val_q == op.value);
	assign hit_out = hit_in | eq;
	assign val     = val_q;

	always_ff @(posedge clk) begin
		if (op.ins && !lt) begin
			// first cell not below the value takes it, the rest shift right
			val_q <= left_lt ? op.value : left_val;
		end else if (op.rem && hit_out) begin
			// close the gap from the right
			val_q <= right_val;
		end
	end

endmodule
